// File: rtl/core/m64chk_pkg.sv
package m64chk_pkg;

  // field and register widths
  localparam int unsigned WORD_WIDTH  = 64;
  localparam int unsigned HALF_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH = 20;
  localparam int unsigned LIMIT_WIDTH = 20;
  localparam int unsigned ADDR_WIDTH  = 4;

  // seed and finaliser constants
  localparam logic [WORD_WIDTH-1:0] SEED_VALUE = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_WIDTH-1:0] MUL_ONE    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_WIDTH-1:0] MUL_TWO    = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned SHIFT_ONE   = 30;
  localparam int unsigned SHIFT_TWO   = 27;
  localparam int unsigned SHIFT_THREE = 31;

  // reset values of the registers
  localparam logic [WORD_WIDTH-1:0]  EXPECTED_RESET   = 64'h0;
  localparam logic [LIMIT_WIDTH-1:0] WORD_LIMIT_RESET = 20'd131069;

  // register indexes (byte address bit 3)
  localparam logic REG_EXPECTED   = 1'b0;
  localparam logic REG_WORD_LIMIT = 1'b1;

  // status codes
  localparam logic [1:0] ST_SUCCESS     = 2'd0;
  localparam logic [1:0] ST_INPUT_ERROR = 2'd1;
  localparam logic [1:0] ST_MISMATCH    = 2'd2;

  // partial product selected for the shared 32x32 multiplier
  typedef enum logic [1:0] {
    PH_CROSS0,
    PH_CROSS1,
    PH_LOW
  } mul_phase_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take_word;
    logic       mul_en;
    mul_phase_t phase;
    logic       second;
    logic       emit;
  } dp_cmd_t;

endpackage

// File: rtl/core/mix64_chain_hash_checker.sv
// Hashes a message of 64-bit words with the splitmix64 finaliser chained
// from the golden-ratio seed, and on a finish item returns the hash with a
// status: success, mismatch against expected_value, or input error when more
// than word_limit words arrived (hash then reads zero). An item carrying a word
// is folded in when taken, then the input stalls while a single 32x32
// multiplier forms three partial products for each of the two 64-bit
// multiplies. A finish item then loads the result register once the result
// slot is free; the register holds the result until taken.
// Registers: expected_value at byte address 0x0, word_limit at 0x8 (64-bit
// data, address bit 3 selects the register).
module mix64_chain_hash_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  // apb-style register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [m64chk_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [m64chk_pkg::WORD_WIDTH-1:0]      pwdata,
  output logic [m64chk_pkg::WORD_WIDTH-1:0]      prdata,
  output logic                                   pready,
  // input items
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [m64chk_pkg::WORD_WIDTH-1:0]      data_word,
  input  logic                                   has_word,
  input  logic                                   finish,
  // result items
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [m64chk_pkg::WORD_WIDTH-1:0]      hash_value,
  output logic [1:0]                             status_code
);
  import m64chk_pkg::*;

  logic [WORD_WIDTH-1:0]  expected_value;
  logic [LIMIT_WIDTH-1:0] word_limit;
  logic                   reg_sel;
  logic                   reg_write;
  dp_cmd_t                cmd;

  // register decode
  assign pready    = 1'b1;
  assign reg_sel   = paddr[3];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_value <= EXPECTED_RESET;
      word_limit     <= WORD_LIMIT_RESET;
    end else if (reg_write) begin
      case (reg_sel)
        REG_EXPECTED:   expected_value <= pwdata;
        REG_WORD_LIMIT: word_limit     <= pwdata[LIMIT_WIDTH-1:0];
        default:        word_limit     <= word_limit;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_sel)
      REG_EXPECTED:   prdata = expected_value;
      REG_WORD_LIMIT: prdata = {{(WORD_WIDTH-LIMIT_WIDTH){1'b0}}, word_limit};
      default:        prdata = '0;
    endcase
  end

  m64chk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .has_word  (has_word),
    .finish    (finish),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  m64chk_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .data_word      (data_word),
    .expected_value (expected_value),
    .word_limit     (word_limit),
    .hash_value     (hash_value),
    .status_code    (status_code)
  );

endmodule

// File: rtl/core/m64chk_ctrl.sv
module m64chk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              has_word,
  input  logic              finish,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output m64chk_pkg::dp_cmd_t cmd
);
  import m64chk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_CROSS0,
    S_A_CROSS1,
    S_A_LOW,
    S_B_CROSS0,
    S_B_CROSS1,
    S_B_LOW,
    S_EMIT
  } state_t;

  state_t state;
  logic   finish_pending;
  logic   in_accept;
  logic   slot_free;

  // input taken only between items; result slot frees when taken
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // command decode from state
  always_comb begin
    cmd           = '0;
    cmd.take_word = in_accept && has_word;
    case (state)
      S_A_CROSS0: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_CROSS0;
      end
      S_A_CROSS1: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_CROSS1;
      end
      S_A_LOW: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_LOW;
      end
      S_B_CROSS0: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_CROSS0;
        cmd.second = 1'b1;
      end
      S_B_CROSS1: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_CROSS1;
        cmd.second = 1'b1;
      end
      S_B_LOW: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_LOW;
        cmd.second = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = slot_free;
      end
      default: begin
        cmd.mul_en = 1'b0;
      end
    endcase
  end

  // sequencer, pending finish and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      finish_pending <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            finish_pending <= finish;
            if (has_word) begin
              state <= S_A_CROSS0;
            end else if (finish) begin
              state <= S_EMIT;
            end
          end
        end
        S_A_CROSS0: state <= S_A_CROSS1;
        S_A_CROSS1: state <= S_A_LOW;
        S_A_LOW:    state <= S_B_CROSS0;
        S_B_CROSS0: state <= S_B_CROSS1;
        S_B_CROSS1: state <= S_B_LOW;
        S_B_LOW: begin
          state <= finish_pending ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (slot_free) begin
            state          <= S_IDLE;
            finish_pending <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result is loaded only into a free slot
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // a loaded result is offered in the next cycle
  a_emit_then_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("loaded result not offered");

  // a word item starts the first multiply
  a_word_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && has_word) |=> (state == S_A_CROSS0))
    else $error("word item did not start hashing");

  // a finishing word goes on to emit after the second multiply
  a_finish_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_LOW && finish_pending) |=> (state == S_EMIT))
    else $error("finish item lost after hashing");

endmodule

// File: rtl/core/m64chk_dp.sv
module m64chk_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  m64chk_pkg::dp_cmd_t                    cmd,
  input  logic [m64chk_pkg::WORD_WIDTH-1:0]      data_word,
  input  logic [m64chk_pkg::WORD_WIDTH-1:0]      expected_value,
  input  logic [m64chk_pkg::LIMIT_WIDTH-1:0]     word_limit,
  output logic [m64chk_pkg::WORD_WIDTH-1:0]      hash_value,
  output logic [1:0]                             status_code
);
  import m64chk_pkg::*;

  logic [WORD_WIDTH-1:0]  accumulator;
  logic [COUNT_WIDTH-1:0] word_counter;
  logic                   overflow_flag;
  logic [WORD_WIDTH-1:0]  x;
  logic [HALF_WIDTH-1:0]  cross_sum;

  logic [WORD_WIDTH-1:0]  x_in;
  logic [WORD_WIDTH-1:0]  x_mix;
  logic [WORD_WIDTH-1:0]  mul_const;
  logic [HALF_WIDTH-1:0]  mul_a;
  logic [HALF_WIDTH-1:0]  mul_b;
  logic [WORD_WIDTH-1:0]  mprod;
  logic [WORD_WIDTH-1:0]  full;
  logic                   limit_hit;

  // fold the word and apply the first xor-shift
  assign x_in  = accumulator ^ data_word;
  assign x_mix = x_in ^ (x_in >> SHIFT_ONE);

  // operand halves for the shared multiplier
  assign mul_const = cmd.second ? MUL_TWO : MUL_ONE;
  always_comb begin
    case (cmd.phase)
      PH_CROSS0: begin
        mul_a = x[HALF_WIDTH-1:0];
        mul_b = mul_const[WORD_WIDTH-1:HALF_WIDTH];
      end
      PH_CROSS1: begin
        mul_a = x[WORD_WIDTH-1:HALF_WIDTH];
        mul_b = mul_const[HALF_WIDTH-1:0];
      end
      default: begin
        mul_a = x[HALF_WIDTH-1:0];
        mul_b = mul_const[HALF_WIDTH-1:0];
      end
    endcase
  end

  assign mprod = {{HALF_WIDTH{1'b0}}, mul_a} * {{HALF_WIDTH{1'b0}}, mul_b};
  // low 64 bits of the full product: cross terms shifted up plus low term
  assign full  = {cross_sum, {HALF_WIDTH{1'b0}}} + mprod;

  assign limit_hit = (word_counter >= word_limit) || (word_counter == '1);

  // message state: accumulator, word count, overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= SEED_VALUE;
      word_counter  <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.take_word) begin
        if (limit_hit) begin
          overflow_flag <= 1'b1;
        end else begin
          word_counter <= word_counter + 1'b1;
        end
      end
      if (cmd.mul_en && cmd.second && cmd.phase == PH_LOW) begin
        accumulator <= full ^ (full >> SHIFT_THREE);
      end
      if (cmd.emit) begin
        accumulator   <= SEED_VALUE;
        word_counter  <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // working value and partial products
  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      x <= x_mix;
    end
    if (cmd.mul_en) begin
      case (cmd.phase)
        PH_CROSS0: cross_sum <= mprod[HALF_WIDTH-1:0];
        PH_CROSS1: cross_sum <= cross_sum + mprod[HALF_WIDTH-1:0];
        PH_LOW: begin
          if (!cmd.second) begin
            x <= full ^ (full >> SHIFT_TWO);
          end
        end
        default: cross_sum <= cross_sum;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (overflow_flag) begin
        hash_value  <= '0;
        status_code <= ST_INPUT_ERROR;
      end else if (accumulator == expected_value) begin
        hash_value  <= accumulator;
        status_code <= ST_SUCCESS;
      end else begin
        hash_value  <= accumulator;
        status_code <= ST_MISMATCH;
      end
    end
  end

  // a finished message leaves a fresh accumulator
  a_reseed: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (accumulator == SEED_VALUE && word_counter == '0 && !overflow_flag))
    else $error("accumulator not re-seeded after finish");

endmodule

// File: tb/tb_mix64_chain_hash_checker.sv
`timescale 1ns / 1ps

module tb_mix64_chain_hash_checker;
  import m64chk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned QUIET_GAP   = 16;
  localparam int unsigned LONG_HOLD   = 300;

  typedef struct {
    logic [WORD_WIDTH-1:0] word;
    logic                  has_word;
    logic                  finish;
  } msg_item_t;

  typedef struct {
    logic [WORD_WIDTH-1:0] hash;
    logic [1:0]            status;
  } hash_result_t;

  // block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [WORD_WIDTH-1:0] pwdata = '0;
  logic [WORD_WIDTH-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [WORD_WIDTH-1:0] data_word = '0;
  logic                  has_word = 1'b0;
  logic                  finish = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_WIDTH-1:0] hash_value;
  logic [1:0]            status_code;

  // predictor state and register mirror
  logic [WORD_WIDTH-1:0]  msg_acc = SEED_VALUE;
  logic [COUNT_WIDTH-1:0] msg_count = '0;
  logic                   msg_overflow = 1'b0;
  logic [WORD_WIDTH-1:0]  cfg_expected = EXPECTED_RESET;
  logic [LIMIT_WIDTH-1:0] cfg_word_limit = WORD_LIMIT_RESET;

  // queues between stimulus, driver and monitor
  msg_item_t             item_backlog[$];
  hash_result_t          pending_results[$];
  logic [WORD_WIDTH-1:0] golden_words[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned item_count = 0;
  int unsigned cfg_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[3] = '{0, 0, 0};

  mix64_chain_hash_checker i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_word   (data_word),
    .has_word    (has_word),
    .finish      (finish),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value  (hash_value),
    .status_code (status_code)
  );

  // clock
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endfunction

  // one word through xor and the splitmix64 finaliser
  function automatic logic [WORD_WIDTH-1:0] splitmix_fold(input logic [WORD_WIDTH-1:0] acc,
                                                          input logic [WORD_WIDTH-1:0] w);
    logic [WORD_WIDTH-1:0] x;
    x = acc ^ w;
    x = x ^ (x >> SHIFT_ONE);
    x = x * MUL_ONE;
    x = x ^ (x >> SHIFT_TWO);
    x = x * MUL_TWO;
    x = x ^ (x >> SHIFT_THREE);
    return x;
  endfunction

  function automatic logic [WORD_WIDTH-1:0] golden_hash();
    logic [WORD_WIDTH-1:0] acc;
    acc = SEED_VALUE;
    foreach (golden_words[i]) acc = splitmix_fold(acc, golden_words[i]);
    return acc;
  endfunction

  // predicted effect of one accepted item
  function automatic void track_message(input logic [WORD_WIDTH-1:0] w, input logic hw,
                                        input logic fin);
    hash_result_t res;
    if (hw) begin
      msg_acc = splitmix_fold(msg_acc, w);
      if (msg_count >= cfg_word_limit || msg_count == '1) msg_overflow = 1'b1;
      else msg_count = msg_count + 1'b1;
    end
    if (fin) begin
      if (msg_overflow) begin
        res.hash   = '0;
        res.status = ST_INPUT_ERROR;
      end else if (msg_acc == cfg_expected) begin
        res.hash   = msg_acc;
        res.status = ST_SUCCESS;
      end else begin
        res.hash   = msg_acc;
        res.status = ST_MISMATCH;
      end
      pending_results.push_back(res);
      msg_acc      = SEED_VALUE;
      msg_count    = '0;
      msg_overflow = 1'b0;
    end
  endfunction

  // driver: next item from the backlog, random gaps on the sender side
  always @(posedge clk) begin
    msg_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) track_message(data_word, has_word, finish);
      if (item_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = item_backlog.pop_front();
        in_valid  <= 1'b1;
        data_word <= nxt.word;
        has_word  <= nxt.has_word;
        finish    <= nxt.finish;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare results, drive receiver stalls and long hold-offs
  always @(posedge clk) begin
    hash_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result hash", '0, hash_value);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (hash_value !== want.hash) flag_mismatch("hash_value", want.hash, hash_value);
          if (status_code !== want.status)
            flag_mismatch("status_code", 64'(want.status), 64'(status_code));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  function automatic logic [WORD_WIDTH-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_item(input logic [WORD_WIDTH-1:0] w, input logic hw,
                                   input logic fin);
    msg_item_t it;
    it.word     = w;
    it.has_word = hw;
    it.finish   = fin;
    item_backlog.push_back(it);
    if (hw || fin) item_count++;
  endfunction

  // queue one message, either the golden words or n random ones, with
  // scattered idle items; a bare finish item closes it where asked
  function automatic void send_message(input bit from_golden, input int n_rand,
                                       input bit bare_end, input bit close_it);
    int n;
    logic [WORD_WIDTH-1:0] w;
    n = from_golden ? golden_words.size() : n_rand;
    for (int i = 0; i < n; i++) begin
      w = from_golden ? golden_words[i] : rand_word();
      if ($urandom_range(7) == 0) add_item(rand_word(), 1'b0, 1'b0);
      add_item(w, 1'b1, close_it && !bare_end && (i == n - 1));
    end
    if (close_it && (bare_end || n == 0)) add_item(rand_word(), 1'b0, 1'b1);
  endfunction

  // register write at setup and access, then read back in the same way
  task automatic cfg_write(input logic reg_sel, input logic [WORD_WIDTH-1:0] value);
    logic [WORD_WIDTH-1:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_EXPECTED) cfg_expected = value;
    else cfg_word_limit = value[LIMIT_WIDTH-1:0];
    cfg_count++;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (reg_sel == REG_EXPECTED) begin
      if (rd !== cfg_expected) flag_mismatch("expected_value read-back", cfg_expected, rd);
    end else if (rd[LIMIT_WIDTH-1:0] !== cfg_word_limit) begin
      flag_mismatch("word limit read-back", 64'(cfg_word_limit), 64'(rd[LIMIT_WIDTH-1:0]));
    end
  endtask

  // wait until all items went in and all results came out, then let the
  // block finish any word still in its multiplier
  task automatic wait_quiet();
    while (item_backlog.size() > 0 || in_valid || pending_results.size() > 0)
      @(negedge clk);
    repeat (QUIET_GAP) @(negedge clk);
  endtask

  initial begin
    logic [LIMIT_WIDTH-1:0] mw;
    logic [WORD_WIDTH-1:0]  ev;
    int                     mode;
    int                     n_gold;
    bit                     pressed;
    pressed = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: empty message gives the seed, mismatching zero
    add_item(64'h0123_4567_89ab_cdef, 1'b0, 1'b1);
    add_item('0, 1'b1, 1'b1);
    add_item('1, 1'b1, 1'b1);
    // idle item, two words, bare finish
    add_item('1, 1'b0, 1'b0);
    add_item(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    add_item(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0);
    add_item('0, 1'b0, 1'b1);
    wait_quiet();

    // matching message with the limit at its top
    golden_words = '{rand_word(), rand_word(), '0};
    cfg_write(REG_EXPECTED, golden_hash());
    cfg_write(REG_WORD_LIMIT, {44'hfff_ffff_ffff, 20'hfffff});
    send_message(1'b1, 0, 1'b0, 1'b1);
    wait_quiet();

    // no words allowed at all
    cfg_write(REG_WORD_LIMIT, '0);
    send_message(1'b0, 1, 1'b0, 1'b1);
    wait_quiet();

    // one word past the limit, then exactly at it
    cfg_write(REG_WORD_LIMIT, 64'd2);
    send_message(1'b0, 3, 1'b0, 1'b1);
    send_message(1'b0, 2, 1'b1, 1'b1);
    wait_quiet();

    // limit lowered in the middle of a message
    cfg_write(REG_WORD_LIMIT, 64'd3);
    send_message(1'b0, 2, 1'b0, 1'b0);
    wait_quiet();
    cfg_write(REG_WORD_LIMIT, 64'd1);
    send_message(1'b0, 1, 1'b0, 1'b1);
    wait_quiet();

    // expected value changed in the middle of a message
    cfg_write(REG_WORD_LIMIT, 64'd8);
    golden_words = '{rand_word()};
    send_message(1'b1, 0, 1'b0, 1'b0);
    wait_quiet();
    golden_words.push_back(rand_word());
    cfg_write(REG_EXPECTED, golden_hash());
    void'(golden_words.pop_front());
    send_message(1'b1, 0, 1'b0, 1'b1);
    wait_quiet();

    // random phases: per setting, golden and random messages mixed at random
    while (item_count < ITEM_TARGET) begin
      case ($urandom_range(7))
        0:       mw = '0;
        1:       mw = '1;
        2:       mw = WORD_LIMIT_RESET;
        default: mw = LIMIT_WIDTH'($urandom_range(1, 10));
      endcase
      golden_words.delete();
      n_gold = $urandom_range(0, (mw < 8) ? mw : 8);
      for (int i = 0; i < n_gold; i++)
        golden_words.push_back(rand_word());
      case ($urandom_range(7))
        0:       ev = '0;
        1:       ev = '1;
        default: ev = golden_hash();
      endcase
      cfg_write(REG_EXPECTED, ev);
      cfg_write(REG_WORD_LIMIT, {$urandom, 12'($urandom), mw});

      mode = (item_count < ITEM_TARGET / 3) ? 0 : (item_count < 2 * ITEM_TARGET / 3) ? 1 : 2;
      case (mode)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 23;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // long receiver hold-off while the sender keeps going
      if (mode == 2 && !pressed) begin
        hold_req++;
        pressed = 1'b1;
      end

      for (int m = 0; m < 10; m++) begin
        if ($urandom_range(2) == 0) send_message(1'b1, 0, $urandom_range(3) == 0, 1'b1);
        else send_message(1'b0, $urandom_range(0, 12), $urandom_range(3) == 0, 1'b1);
      end
      wait_quiet();
    end

    $display("covered %0d items under %0d register writes", item_count, cfg_count);
    $display("results: %0d success, %0d input error, %0d mismatch status",
             status_seen[ST_SUCCESS], status_seen[ST_INPUT_ERROR], status_seen[ST_MISMATCH]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/m64chk_pkg.sv
rtl/core/m64chk_ctrl.sv
rtl/core/m64chk_dp.sv
rtl/core/mix64_chain_hash_checker.sv
tb/tb_mix64_chain_hash_checker.sv
